// ----- sv/tpwm_pkg.sv -----
`default_nettype none
// Package with the shared types, constants and sine table function of the three-phase PWM block.
package tpwm_pkg;

	localparam int COUNTS_PER_CYCLE_DEF = 1024;
	localparam int SINE_BITS_DEF = 16;
	localparam int DATA_W = 16;

	// Number of register stages from an accepted request to its result strobe.
	localparam int PIPE_DEPTH = 8;

	localparam logic [DATA_W-1:0] PWM_PERIOD_RST = 16'd2154;
	localparam logic DT_ENABLE_RST = 1'b0;
	localparam logic [DATA_W-1:0] DT_FRACTION_RST = 16'd655;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int unsigned SINE_DIVS [6] = '{156, 110, 72, 42, 20, 6};

	typedef enum logic [1:0] {
		REG_PWM_PERIOD  = 2'd0,
		REG_DT_ENABLE   = 2'd1,
		REG_DT_FRACTION = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SGN_ZERO,
		SGN_POS,
		SGN_NEG
	} dt_sign_t;

	typedef struct packed {
		logic [DATA_W-1:0] period;
		logic              dt_enable;
		logic [DATA_W-1:0] dt_fraction;
	} cfg_t;

	// Quantized sine of a 32-bit phase word, evaluated at elaboration to fill the table.
	function automatic logic signed [31:0] sine_from_phase(input logic [63:0] t,
			input int sine_bits);
		logic        neg;
		logic [63:0] h;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] r;
		logic [63:0] s;
		logic [63:0] mag;
		logic [63:0] cap;
		neg = (t >= (64'd1 << 31));
		h = t & ((64'd1 << 31) - 64'd1);
		if (h > Q30_ONE) begin
			h = (64'd1 << 31) - h;
		end
		x = (h * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		r = Q30_ONE;
		for (int i = 0; i < 6; i++) begin
			r = Q30_ONE - (((x2 * r) >> 30) / 64'(SINE_DIVS[i]));
		end
		s = (x * r) >> 30;
		mag = (s + (64'd1 << (30 - sine_bits))) >> (31 - sine_bits);
		cap = (64'd1 << (sine_bits - 1)) - 64'd1;
		if (mag > cap) begin
			mag = cap;
		end
		return neg ? (32'd0 - mag[31:0]) : mag[31:0];
	endfunction

endpackage
`default_nettype wire

// ----- sv/tpwm_sine_rom.sv -----
`default_nettype none
// Constant sine table with one registered read port.
module tpwm_sine_rom #(
	parameter int COUNTS_PER_CYCLE = tpwm_pkg::COUNTS_PER_CYCLE_DEF,
	parameter int SINE_BITS = tpwm_pkg::SINE_BITS_DEF,
	localparam int KW = $clog2(COUNTS_PER_CYCLE)
) (
	input  wire logic                        clk,
	input  wire logic [KW-1:0]               addr,
	output logic signed [SINE_BITS-1:0]      data
);

	logic signed [SINE_BITS-1:0] rom [COUNTS_PER_CYCLE];

	for (genvar i = 0; i < COUNTS_PER_CYCLE; i++) begin : g_entry
		localparam logic [63:0] PHASE = (64'(i) << 32) / COUNTS_PER_CYCLE;
		assign rom[i] = SINE_BITS'(tpwm_pkg::sine_from_phase(PHASE, SINE_BITS));
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end

endmodule
`default_nettype wire

// ----- sv/tpwm_phase.sv -----
`default_nettype none
// Eight-stage datapath that turns position and power into the compare value of one phase.
module tpwm_phase #(
	parameter int COUNTS_PER_CYCLE = tpwm_pkg::COUNTS_PER_CYCLE_DEF,
	parameter int SINE_BITS = tpwm_pkg::SINE_BITS_DEF,
	parameter int PHASE_OFFSET = 0,
	localparam int KW = $clog2(COUNTS_PER_CYCLE)
) (
	input  wire logic                          clk,
	input  wire logic [tpwm_pkg::DATA_W-1:0]   position,
	input  wire logic [tpwm_pkg::DATA_W-1:0]   power_level,
	input  wire tpwm_pkg::cfg_t                cfg,
	output logic [tpwm_pkg::DATA_W-1:0]        compare
);

	localparam int DW = tpwm_pkg::DATA_W;
	localparam int VW = DW + 1;
	localparam int RS = 34;
	localparam int RW = RS + 1;
	localparam int PW = VW + RW;
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << RS) / COUNTS_PER_CYCLE);
	localparam logic [VW-1:0] NV = VW'(COUNTS_PER_CYCLE);
	localparam logic [KW:0] NK = (KW + 1)'(COUNTS_PER_CYCLE);
	localparam logic [SINE_BITS-1:0] FHALF = SINE_BITS'(1) << (SINE_BITS - 1);
	localparam int AW = SINE_BITS + 18;
	localparam int LOW = AW / 2;
	localparam int HIW = AW - LOW;
	localparam int LPW = DW + LOW;
	localparam int HPW = DW + 1 + HIW;
	localparam int NW = AW + 18;
	localparam int NCW = SINE_BITS + 31;
	localparam int MW = NCW - 32 + DW;
	localparam int SW = MW + 1;
	localparam logic signed [NW-1:0] DEN = NW'(1) << (SINE_BITS + 30);

	// Stage 1: offset position and reciprocal product for the modulo.
	logic [VW-1:0] v_in;
	logic [PW-1:0] prod_in;
	logic [VW-1:0] v_s1;
	logic [PW-1:0] prod_s1;
	logic [DW-1:0] p_s1;

	assign v_in = VW'(position) + VW'(PHASE_OFFSET);
	assign prod_in = PW'(v_in) * PW'(RECIP);

	always_ff @(posedge clk) begin
		v_s1 <= v_in;
		prod_s1 <= prod_in;
		p_s1 <= power_level;
	end

	// Stage 2: the quotient estimate is at most one low, so one correction finishes the modulo.
	logic [VW-1:0] q_est;
	logic [VW-1:0] qn;
	logic [VW-1:0] rem;
	logic [VW-1:0] rem_fix;
	logic [KW-1:0] k_s2;
	logic [DW-1:0] p_s2;

	assign q_est = prod_s1[RS +: VW];
	assign qn = q_est * NV;
	assign rem = v_s1 - qn;
	assign rem_fix = (rem >= NV) ? (rem - NV) : rem;

	always_ff @(posedge clk) begin
		k_s2 <= rem_fix[KW-1:0];
		p_s2 <= p_s1;
	end

	// Stage 3: table read and dead-time sign from the exact step.
	logic signed [SINE_BITS-1:0] sin_s3;
	logic [KW:0]                 twice_k;
	tpwm_pkg::dt_sign_t          sgn_in;
	tpwm_pkg::dt_sign_t          sgn_s3;
	logic [DW-1:0]               p_s3;

	tpwm_sine_rom #(
		.COUNTS_PER_CYCLE(COUNTS_PER_CYCLE),
		.SINE_BITS(SINE_BITS)
	) u_rom (
		.clk(clk),
		.addr(k_s2),
		.data(sin_s3)
	);

	assign twice_k = {k_s2, 1'b0};

	always_comb begin
		if (k_s2 == '0 || twice_k == NK) begin
			sgn_in = tpwm_pkg::SGN_ZERO;
		end else if (twice_k < NK) begin
			sgn_in = tpwm_pkg::SGN_POS;
		end else begin
			sgn_in = tpwm_pkg::SGN_NEG;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s3 <= sgn_in;
		p_s3 <= p_s2;
	end

	// Stage 4: numerator factor without power, (S + F) * 2^16 +/- D * 2F.
	logic [SINE_BITS-1:0]     off_sin;
	logic signed [AW-1:0]     base_a;
	logic signed [AW-1:0]     dt_sh;
	logic signed [AW-1:0]     a_in;
	logic signed [AW-1:0]     a_s4;
	logic [DW-1:0]            p_s4;

	assign off_sin = $unsigned(sin_s3) + FHALF;
	assign base_a = $signed({2'b00, off_sin, 16'b0});
	assign dt_sh = AW'($signed(cfg.dt_fraction)) <<< SINE_BITS;

	always_comb begin
		a_in = base_a;
		if (cfg.dt_enable) begin
			case (sgn_s3)
				tpwm_pkg::SGN_POS: a_in = base_a + dt_sh;
				tpwm_pkg::SGN_NEG: a_in = base_a - dt_sh;
				default:           a_in = base_a;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		a_s4 <= a_in;
		p_s4 <= p_s3;
	end

	// Stage 5: power times the factor, split into two partial products.
	logic [LPW-1:0]        pp_lo_s5;
	logic signed [HPW-1:0] pp_hi_s5;

	always_ff @(posedge clk) begin
		pp_lo_s5 <= p_s4 * a_s4[LOW-1:0];
		pp_hi_s5 <= $signed({1'b0, p_s4}) * $signed(a_s4[AW-1:LOW]);
	end

	// Stage 6: combine and clamp the duty numerator to [0, 2^(SINE_BITS+30)].
	logic signed [NW-1:0] num;
	logic [NCW-1:0]       numc_s6;

	assign num = $signed(NW'(pp_hi_s5) << LOW) + $signed(NW'(pp_lo_s5));

	always_ff @(posedge clk) begin
		if (num < 0) begin
			numc_s6 <= '0;
		end else if (num > DEN) begin
			numc_s6 <= DEN[NCW-1:0];
		end else begin
			numc_s6 <= num[NCW-1:0];
		end
	end

	// Stage 7: scale by the period in two halves.
	logic [32+DW-1:0] lo_prod;
	logic [MW-1:0]    mhi_s7;
	logic [DW-1:0]    mlo_s7;

	assign lo_prod = numc_s6[31:0] * cfg.period;

	always_ff @(posedge clk) begin
		mhi_s7 <= numc_s6[NCW-1:32] * cfg.period;
		mlo_s7 <= lo_prod[32 +: DW];
	end

	// Stage 8: final sum and truncating shift.
	logic [SW-1:0] scaled;
	logic [DW-1:0] cmp_s8;

	assign scaled = SW'(mhi_s7) + SW'(mlo_s7);

	always_ff @(posedge clk) begin
		cmp_s8 <= scaled[SINE_BITS-2 +: DW];
	end

	assign compare = cmp_s8;

endmodule
`default_nettype wire

// ----- sv/three_phase_sine_pwm_duty_top.sv -----
`default_nettype none
// Top level of the three-phase sinusoidal PWM duty generator.
//
// Channel   Signals                                  Handshake
// request   start, busy, position, power_level      taken when start high and busy low
// result    done, compare_a, compare_b, compare_c   done strobe, one cycle, no back-pressure
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  written when valid and ready high
//
// One request is taken every cycle while busy is low; each result appears after
// the eight register stages of the per-phase datapath.
// The sine table is constant logic, so there is no fill or clearing pass after reset.
// busy is high during reset and until the first clock edge after it, and low from then on.
// Results cannot be held off, so the pipeline never stalls.
module three_phase_sine_pwm_duty_top #(
	parameter int COUNTS_PER_CYCLE = tpwm_pkg::COUNTS_PER_CYCLE_DEF,
	parameter int SINE_BITS = tpwm_pkg::SINE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [tpwm_pkg::DATA_W-1:0]   position,
	input  wire logic [tpwm_pkg::DATA_W-1:0]   power_level,
	output logic                               done,
	output logic [tpwm_pkg::DATA_W-1:0]        compare_a,
	output logic [tpwm_pkg::DATA_W-1:0]        compare_b,
	output logic [tpwm_pkg::DATA_W-1:0]        compare_c,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [tpwm_pkg::DATA_W-1:0]   cfg_data
);

	localparam int DEPTH = tpwm_pkg::PIPE_DEPTH;
	localparam int OFFSET_B = COUNTS_PER_CYCLE / 3;
	localparam int OFFSET_C = (COUNTS_PER_CYCLE * 2) / 3;

	tpwm_pkg::cfg_t   cfg_q;
	logic             busy_q;
	logic [DEPTH-1:0] vld_q;
	logic             accept;

	assign accept = start && !busy_q;
	assign busy = busy_q;
	assign cfg_ready = 1'b1;
	assign done = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[DEPTH-2:0], accept};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period <= tpwm_pkg::PWM_PERIOD_RST;
			cfg_q.dt_enable <= tpwm_pkg::DT_ENABLE_RST;
			cfg_q.dt_fraction <= tpwm_pkg::DT_FRACTION_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (tpwm_pkg::cfg_reg_t'(cfg_index))
				tpwm_pkg::REG_PWM_PERIOD:  cfg_q.period <= cfg_data;
				tpwm_pkg::REG_DT_ENABLE:   cfg_q.dt_enable <= cfg_data[0];
				tpwm_pkg::REG_DT_FRACTION: cfg_q.dt_fraction <= cfg_data;
				default: ;
			endcase
		end
	end

	tpwm_phase #(
		.COUNTS_PER_CYCLE(COUNTS_PER_CYCLE),
		.SINE_BITS(SINE_BITS),
		.PHASE_OFFSET(0)
	) u_phase_a (
		.clk(clk),
		.position(position),
		.power_level(power_level),
		.cfg(cfg_q),
		.compare(compare_a)
	);

	tpwm_phase #(
		.COUNTS_PER_CYCLE(COUNTS_PER_CYCLE),
		.SINE_BITS(SINE_BITS),
		.PHASE_OFFSET(OFFSET_B)
	) u_phase_b (
		.clk(clk),
		.position(position),
		.power_level(power_level),
		.cfg(cfg_q),
		.compare(compare_b)
	);

	tpwm_phase #(
		.COUNTS_PER_CYCLE(COUNTS_PER_CYCLE),
		.SINE_BITS(SINE_BITS),
		.PHASE_OFFSET(OFFSET_C)
	) u_phase_c (
		.clk(clk),
		.position(position),
		.power_level(power_level),
		.cfg(cfg_q),
		.compare(compare_c)
	);

endmodule
`default_nettype wire

// ----- sv/tpwm_checker.sv -----
`default_nettype none
// Port-level checker for the three-phase PWM duty block and its bind to the top level.
module tpwm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic [tpwm_pkg::DATA_W-1:0]   power_level,
	input wire logic                          done,
	input wire logic [tpwm_pkg::DATA_W-1:0]   compare_a,
	input wire logic [tpwm_pkg::DATA_W-1:0]   compare_b,
	input wire logic [tpwm_pkg::DATA_W-1:0]   compare_c
);

	// Every accepted request produces its result strobe after the PIPE_DEPTH pipeline stages.
	a_request_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(tpwm_pkg::PIPE_DEPTH) done)
		else $error("accepted request did not produce a result on time");

	// No result strobe appears without a request at the matching earlier edge.
	a_result_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, tpwm_pkg::PIPE_DEPTH))
		else $error("result strobe without a matching request");

	// Zero power gives zero duty on all phases, with or without dead-time offset.
	a_zero_power: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && power_level == '0) |-> ##(tpwm_pkg::PIPE_DEPTH)
		(compare_a == '0 && compare_b == '0 && compare_c == '0))
		else $error("zero power request gave a nonzero compare value");

endmodule

bind three_phase_sine_pwm_duty_top tpwm_checker u_tpwm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.power_level(power_level),
	.done(done),
	.compare_a(compare_a),
	.compare_b(compare_b),
	.compare_c(compare_c)
);
`default_nettype wire
